### hdl/pct_priority_scheduler_unit_assert.svh
// Assertion macros for the scheduler RTL, included by pct_back.
`ifndef PCT_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PCT_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Condition a implies b in the same cycle.
`define PCT_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("scheduler check failed");

// Condition a implies b in the next cycle.
`define PCT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("scheduler check failed");

`endif

### hdl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Types, codes and helpers shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_LIMIT    = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;
  localparam logic [1:0] REG_DEPTH    = 2'd3;

  typedef struct packed {
    logic                 strategy_enabled;
    logic [15:0]          change_point_limit;
    logic [31:0]          modulus_k;
    logic [31:0]          depth_d;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [ID_W-1:0]      task_id;
    logic [63:0]          rand_init_priority;
    logic [63:0]          rand_change;
    logic [MAX_TASKS-1:0] enabled_mask;
    logic                 decide;
  } item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [CNT_W-1:0] popcount(input logic [MAX_TASKS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_TASKS; i++) n = n + CNT_W'(v[i]);
    popcount = n;
  endfunction

endpackage

`default_nettype wire

### hdl/pct_front.sv
// ----------------------------------------------------------------------------
// pct_front
// Accepts event words, decides whether each qualifies for scheduling and
// parks it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          strategy_enabled,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op,
  input  wire logic [pct_pkg::ID_W-1:0]      task_id,
  input  wire logic [63:0]                   rand_init_priority,
  input  wire logic [63:0]                   rand_change,
  input  wire logic [pct_pkg::MAX_TASKS-1:0] enabled_mask,
  input  wire logic                          selector_unset,
  input  wire logic                          already_readonly,
  input  wire logic                          is_sched_point,
  input  wire logic                          skip_event,
  input  wire logic                          q_pop,
  output logic                               q_valid,
  output pct_pkg::item_t                     q_item
);

  pct_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  pct_pkg::item_t in_item;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    in_item.op                 = op;
    in_item.task_id            = task_id;
    in_item.rand_init_priority = rand_init_priority;
    in_item.rand_change        = rand_change;
    in_item.enabled_mask       = enabled_mask;
    in_item.decide = strategy_enabled && selector_unset && !already_readonly &&
                     (pct_pkg::popcount(enabled_mask) > pct_pkg::CNT_W'(1)) &&
                     is_sched_point && !skip_event;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= in_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

### hdl/pct_back.sv
// ----------------------------------------------------------------------------
// pct_back
// Applies each queued event to the task table, runs the change point test
// with a serial remainder unit when the modulus is nonzero, scans the slots
// for the winner and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pct_priority_scheduler_unit_assert.svh"

module pct_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pct_pkg::cfg_t             cfg,
  input  wire logic                      q_valid,
  input  wire pct_pkg::item_t            q_item,
  output logic                           q_pop,
  output logic                           empty,
  input  wire logic                      pop,
  output logic                           decided,
  output logic [pct_pkg::ID_W-1:0]       chosen_task,
  output logic                           priority_changed,
  output logic [31:0]                    steps_counted,
  output logic [15:0]                    change_points_used,
  output logic [4:0]                     peak_tasks
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COUNT = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CHG   = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                      state;
  pct_pkg::item_t              cur;
  logic                        has_task;
  logic [pct_pkg::MAX_TASKS-1:0] valid;
  logic [63:0]                 prio [pct_pkg::MAX_TASKS];
  logic [31:0]                 step_count;
  logic [15:0]                 change_count;
  logic [4:0]                  peak_count;
  logic [31:0]                 rem;
  logic [63:0]                 dividend;
  logic [5:0]                  div_cnt;
  logic [pct_pkg::ID_W-1:0]    scan_idx;
  logic [63:0]                 best;
  logic                        found;
  logic [pct_pkg::ID_W-1:0]    chosen;
  logic                        changed;
  logic                        out_full;
  logic [pct_pkg::CNT_W-1:0]   reg_n;
  logic [32:0]                 trial;
  logic                        rem_ok;
  logic                        load_out;

  assign reg_n  = pct_pkg::popcount(valid);
  assign trial  = {rem, dividend[63]};
  assign rem_ok = (cfg.modulus_k == 32'd0) ? (cur.rand_change <= {32'd0, cfg.depth_d})
                                           : (rem <= cfg.depth_d);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_DONE) && (!out_full || pop);
  assign empty    = !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid        <= '0;
      step_count   <= '0;
      change_count <= '0;
      peak_count   <= '0;
      out_full     <= 1'b0;
    end else begin
      if (load_out) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur     <= q_item;
            changed <= 1'b0;
            found   <= 1'b0;
            chosen  <= '0;
            case (q_item.op)
              pct_pkg::OP_START: begin
                valid[q_item.task_id] <= 1'b1;
                prio[q_item.task_id]  <= q_item.rand_init_priority;
                has_task              <= 1'b1;
              end
              pct_pkg::OP_END: begin
                valid[q_item.task_id] <= 1'b0;
                has_task              <= 1'b0;
              end
              default: has_task <= valid[q_item.task_id];
            endcase
            state <= q_item.decide ? ST_COUNT : ST_DONE;
          end
        end
        ST_COUNT: begin
          if (5'(reg_n) > peak_count) peak_count <= 5'(reg_n);
          step_count <= pct_pkg::sat_inc(step_count);
          if (has_task && reg_n > pct_pkg::CNT_W'(1)) begin
            rem      <= '0;
            dividend <= cur.rand_change;
            div_cnt  <= '0;
            state    <= (cfg.modulus_k == 32'd0) ? ST_CHG : ST_DIV;
          end else begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          if (trial >= {1'b0, cfg.modulus_k}) rem <= 32'(trial - {1'b0, cfg.modulus_k});
          else rem <= trial[31:0];
          dividend <= {dividend[62:0], 1'b0};
          div_cnt  <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) state <= ST_CHG;
        end
        ST_CHG: begin
          if (change_count < cfg.change_point_limit && rem_ok) begin
            prio[cur.task_id] <= cur.rand_change;
            changed           <= 1'b1;
            change_count      <= change_count + 16'd1;
          end
          step_count <= pct_pkg::sat_inc(step_count);
          scan_idx   <= '0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur.enabled_mask[scan_idx] && valid[scan_idx] &&
              (!found || prio[scan_idx] > best)) begin
            found  <= 1'b1;
            best   <= prio[scan_idx];
            chosen <= scan_idx;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == pct_pkg::ID_W'(pct_pkg::MAX_TASKS - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      decided            <= cur.decide;
      chosen_task        <= chosen;
      priority_changed   <= changed;
      steps_counted      <= step_count;
      change_points_used <= change_count;
      peak_tasks         <= peak_count;
    end
  end

  `PCT_ASSERT_NOW(a_change_needs_decide, clk, rst, changed && state != ST_IDLE, cur.decide)
  `PCT_ASSERT_NOW(a_div_needs_task, clk, rst, state == ST_DIV, has_task)
  `PCT_ASSERT_NEXT(a_hold_when_stalled, clk, rst,
                   state == ST_DONE && out_full && !pop, state == ST_DONE)

endmodule

`default_nettype wire

### hdl/pct_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// pct_priority_scheduler_unit
// Priority scheduler for probabilistic concurrency testing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive an event word on the field ports and raise push;
//   the word is taken on a clock edge with push high and full low. A
//   two-entry queue sits behind the input, so two words may wait.
//   Result channel: while empty is low the result of the oldest word is on
//   the result ports; it is taken on an edge with pop high.
//   Configuration: write cfg_data to register cfg_index with cfg_we, only
//   while no word is in flight.
//   Path per word: a word that needs no decision goes from the queue
//   straight to the result register; a decision counts the step and scans
//   all 16 slots, and a change point test first runs the serial remainder
//   unit over all 64 dividend bits, skipped when the modulus is zero.
//   One word is worked on at a time.
//   Reset (rst, synchronous): task table empty, counters zero, strategy off,
//   modulus one, queues empty.
//   When pop stays low the finished result holds and the back end waits;
//   the input queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_priority_scheduler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op,
  input  wire logic [pct_pkg::ID_W-1:0]      task_id,
  input  wire logic [63:0]                   rand_init_priority,
  input  wire logic [63:0]                   rand_change,
  input  wire logic [pct_pkg::MAX_TASKS-1:0] enabled_mask,
  input  wire logic                          selector_unset,
  input  wire logic                          already_readonly,
  input  wire logic                          is_sched_point,
  input  wire logic                          skip_event,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               decided,
  output logic [pct_pkg::ID_W-1:0]           chosen_task,
  output logic                               priority_changed,
  output logic [31:0]                        steps_counted,
  output logic [15:0]                        change_points_used,
  output logic [4:0]                         peak_tasks
);

  pct_pkg::cfg_t  cfg;
  logic           q_valid;
  logic           q_pop;
  pct_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strategy_enabled   <= 1'b0;
      cfg.change_point_limit <= '0;
      cfg.modulus_k          <= 32'd1;
      cfg.depth_d            <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pct_pkg::REG_STRATEGY: cfg.strategy_enabled   <= cfg_data[0];
        pct_pkg::REG_LIMIT:    cfg.change_point_limit <= cfg_data[15:0];
        pct_pkg::REG_MODULUS:  cfg.modulus_k          <= cfg_data;
        pct_pkg::REG_DEPTH:    cfg.depth_d            <= cfg_data;
        default: ;
      endcase
    end
  end

  pct_front u_front (
    .clk, .rst,
    .strategy_enabled (cfg.strategy_enabled),
    .push, .full, .op, .task_id, .rand_init_priority, .rand_change,
    .enabled_mask, .selector_unset, .already_readonly, .is_sched_point,
    .skip_event,
    .q_pop, .q_valid, .q_item
  );

  pct_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_item, .q_pop, .empty, .pop,
    .decided, .chosen_task, .priority_changed, .steps_counted,
    .change_points_used, .peak_tasks
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pct_priority_scheduler_unit: event words go in
// through the push/full queue port. A behavioral copy of the slot table and
// counters predicts every result word. Results are popped with random
// stalls and compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  typedef struct packed {
    logic        decided;
    logic [3:0]  chosen;
    logic        changed;
    logic [31:0] steps;
    logic [15:0] cps;
    logic [4:0]  peak;
  } sched_result_t;

  // flag order: selector_unset, already_readonly, is_sched_point, skip_event
  localparam logic [3:0] FL_GO = 4'b1010;
  localparam logic [1:0] OP_ODD = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pct_pkg::REG_STRATEGY;
  logic [31:0] cfg_data = '0;
  logic push = 1'b0, pop = 1'b0;
  logic [1:0] op = pct_pkg::OP_EVENT;
  logic [3:0] task_id = '0;
  logic [63:0] rand_init_priority = '0, rand_change = '0;
  logic [15:0] enabled_mask = '0;
  logic selector_unset = 1'b0, already_readonly = 1'b0;
  logic is_sched_point = 1'b0, skip_event = 1'b0;
  wire full, empty, decided, priority_changed;
  wire [3:0] chosen_task;
  wire [31:0] steps_counted;
  wire [15:0] change_points_used;
  wire [4:0] peak_tasks;

  pct_priority_scheduler_unit uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow scheduler state
  logic        slot_live [16];
  logic [63:0] slot_prio [16];
  logic [31:0] step_ctr;
  logic [15:0] change_ctr;
  logic [4:0]  peak_ctr;
  logic        strat_on;
  logic [15:0] cp_limit;
  logic [31:0] mod_k, depth;

  sched_result_t pending_q[$];
  int mismatches = 0, words_in = 0, words_out = 0, decisions = 0, changes = 0;
  int idle_cnt = 0;
  bit gaps_on = 1'b1;

  function automatic sched_result_t schedule_word(logic [1:0] o, logic [3:0] id,
      logic [63:0] rinit, logic [63:0] rchg, logic [15:0] m, logic [3:0] fl);
    sched_result_t r;
    logic has;
    int en_n, reg_n;
    logic found;
    logic [63:0] best, rem;
    r = '0;
    en_n = 0;
    reg_n = 0;
    found = 1'b0;
    best = '0;
    if (o == pct_pkg::OP_END) begin
      slot_live[id] = 1'b0;
      has = 1'b0;
    end else if (o == pct_pkg::OP_START) begin
      slot_live[id] = 1'b1;
      slot_prio[id] = rinit;
      has = 1'b1;
    end else begin
      has = slot_live[id];
    end
    for (int i = 0; i < 16; i++) begin
      en_n += m[i];
      reg_n += slot_live[i];
    end
    if (strat_on && fl[3] && !fl[2] && en_n > 1 && fl[1] && !fl[0]) begin
      if (has && reg_n > 1) begin
        rem = (mod_k != 0) ? rchg % {32'd0, mod_k} : rchg;
        if (step_ctr != 32'hFFFF_FFFF) step_ctr++;
        if (change_ctr < cp_limit && rem <= {32'd0, depth}) begin
          slot_prio[id] = rchg;
          r.changed = 1'b1;
          change_ctr++;
        end
      end
      if (step_ctr != 32'hFFFF_FFFF) step_ctr++;
      for (int i = 0; i < 16; i++) begin
        if (m[i] && slot_live[i] && (!found || slot_prio[i] > best)) begin
          found = 1'b1;
          best = slot_prio[i];
          r.chosen = i[3:0];
        end
      end
      r.decided = 1'b1;
      if (reg_n > 31) reg_n = 31;
      if (reg_n > peak_ctr) peak_ctr = reg_n[4:0];
    end
    r.steps = step_ctr;
    r.cps = change_ctr;
    r.peak = peak_ctr;
    return r;
  endfunction

  // Result side: random pop stalls, compare, watchdog.
  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst) begin
      pop <= !(gaps_on && $urandom_range(99) < 9);
      if (pop && !empty) begin
        words_out++;
        got = '{decided, chosen_task, priority_changed, steps_counted,
                change_points_used, peak_tasks};
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp dec=%0d ch=%0d chg=%0d st=%0d cp=%0d pk=%0d,",
                        " got dec=%0d ch=%0d chg=%0d st=%0d cp=%0d pk=%0d"},
                       want.decided, want.chosen, want.changed, want.steps, want.cps,
                       want.peak, got.decided, got.chosen, got.changed, got.steps,
                       got.cps, got.peak);
          end
        end
      end
      idle_cnt = ((push && !full) || (pop && !empty)) ? 0 : idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] o, logic [3:0] id, logic [63:0] rinit,
      logic [63:0] rchg, logic [15:0] m, logic [3:0] fl);
    sched_result_t r;
    if (gaps_on && $urandom_range(99) < 9) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    op <= o;
    task_id <= id;
    rand_init_priority <= rinit;
    rand_change <= rchg;
    enabled_mask <= m;
    {selector_unset, already_readonly, is_sched_point, skip_event} <= fl;
    push <= 1'b1;
    do @(posedge clk); while (full);
    r = schedule_word(o, id, rinit, rchg, m, fl);
    pending_q.push_back(r);
    words_in++;
    decisions += r.decided;
    changes += r.changed;
  endtask

  // Hold push low and wait until every result word is back.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic s, logic [15:0] l, logic [31:0] k, logic [31:0] d);
    logic [31:0] vals [4];
    vals = '{{31'd0, s}, {16'd0, l}, k, d};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    strat_on = s;
    cp_limit = l;
    mod_k = k;
    depth = d;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_random(bit shaped);
    logic [1:0] o;
    logic [15:0] m;
    logic [3:0] fl;
    int pick;
    pick = $urandom_range(99);
    if (shaped) begin
      o = (pick < 30) ? pct_pkg::OP_START : (pick < 45) ? pct_pkg::OP_END :
          (pick < 48) ? OP_ODD : pct_pkg::OP_EVENT;
      m = 16'($urandom);
      if ($urandom_range(3) == 0) m = m & 16'($urandom);
      if ($countones(m) < 2) m = m | (16'd1 << $urandom_range(15)) | 16'h0001;
      if ($countones(m) < 2) m = m | 16'h8000;
      fl = ($urandom_range(9) == 0) ? 4'($urandom) : FL_GO;
    end else begin
      o = 2'($urandom);
      m = 16'($urandom);
      fl = 4'($urandom);
    end
    send_word(o, 4'($urandom), rnd64(), rnd64(), m, fl);
  endtask

  task automatic test_strategy_off();
    // defaults out of reset: nothing is decided
    for (int i = 0; i < 6; i++) send_random(1'b1);
    drain();
  endtask

  task automatic test_directed();
    set_config(1'b1, 16'd3, 32'd4, 32'd1);
    send_word(pct_pkg::OP_START, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'hFFFF, FL_GO);
    send_word(pct_pkg::OP_START, 4'd15, 64'd0, 64'd5, 16'h8001, FL_GO);
    send_word(pct_pkg::OP_EVENT, 4'd15, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8001, FL_GO);
    send_word(OP_ODD, 4'd0, 64'd7, 64'd2, 16'hFFFF, FL_GO);
    send_word(pct_pkg::OP_START, 4'd3, 64'h55, 64'd9, 16'h0028, FL_GO);
    send_word(pct_pkg::OP_START, 4'd5, 64'h55, 64'd8, 16'h0028, FL_GO);   // change point taken, id 3 still wins
    send_word(pct_pkg::OP_START, 4'd5, 64'h56, 64'd3, 16'h0028, FL_GO);   // re-register
    send_word(pct_pkg::OP_EVENT, 4'd3, 64'd0, 64'd1, 16'h0028, FL_GO);    // limit reached
    send_word(pct_pkg::OP_EVENT, 4'd3, 64'd0, 64'd0, 16'h0028, FL_GO);
    send_word(pct_pkg::OP_EVENT, 4'd9, 64'd0, 64'd0, 16'h0600, FL_GO);    // none registered
    send_word(pct_pkg::OP_EVENT, 4'd0, 64'd0, 64'd0, 16'h0001, FL_GO);    // single enabled
    send_word(pct_pkg::OP_EVENT, 4'd0, 64'd0, 64'd0, 16'hFFFF, 4'b0010);
    send_word(pct_pkg::OP_EVENT, 4'd0, 64'd0, 64'd0, 16'hFFFF, 4'b1110);
    send_word(pct_pkg::OP_EVENT, 4'd0, 64'd0, 64'd0, 16'hFFFF, 4'b1000);
    send_word(pct_pkg::OP_EVENT, 4'd0, 64'd0, 64'd0, 16'hFFFF, 4'b1011);
    send_word(pct_pkg::OP_END, 4'd15, 64'd0, 64'd0, 16'hFFFF, FL_GO);
    send_word(pct_pkg::OP_END, 4'd15, 64'd0, 64'd0, 16'hFFFF, FL_GO);     // already free
    send_word(pct_pkg::OP_END, 4'd0, 64'd0, 64'd0, 16'h8009, FL_GO);
    drain();
  endtask

  task automatic test_modulus_zero();
    set_config(1'b1, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    send_word(pct_pkg::OP_EVENT, 4'd3, 64'd0, 64'h0000_0000_FFFF_FFFF, 16'h0028, FL_GO);
    send_word(pct_pkg::OP_EVENT, 4'd5, 64'd0, 64'h0000_0001_0000_0000, 16'h0028, FL_GO);
    for (int i = 0; i < 30; i++) send_random(1'b1);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] ks [4];
    ks = '{32'd3, 32'hFFFF_FFFF, 32'd1, 32'h8000_0001};
    for (int ph = 0; ph < 4; ph++) begin
      set_config(1'b1, (ph == 2) ? 16'd0 : 16'($urandom_range(20, 65535)), ks[ph],
                 (ph == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 2)));
      for (int i = 0; i < 95; i++) begin
        gaps_on = !(ph == 1 && i >= 20 && i < 80);
        send_random($urandom_range(9) != 0);
      end
      gaps_on = 1'b1;
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      slot_live[i] = 1'b0;
      slot_prio[i] = '0;
    end
    step_ctr = '0;
    change_ctr = '0;
    peak_ctr = '0;
    strat_on = 1'b0;
    cp_limit = '0;
    mod_k = 32'd1;
    depth = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_strategy_off();
    test_directed();
    test_modulus_zero();
    test_random();
    repeat (20) @(posedge clk);
    $display("%0d event words sent, %0d results checked, %0d decisions, %0d change points",
             words_in, words_out, decisions, changes);
    $display("configs: strategy off/on, modulus 0/1/small/max, limit 0 to max");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
